>>> src/bms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg - shared types and constants for the bilinear map sampler
// Fixed widths of the coordinate and blend datapath, register codes.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int ADDR_W      = 16;
    localparam int MAP_DEPTH   = 1 << ADDR_W;
    localparam int WORD_W      = 32;
    localparam int PADDR_W     = 4;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_CORNERS = 4;

    // coordinate path
    localparam int D_W    = WORD_W + 1;          // pos - center
    localparam int PROD_W = D_W + FRAC_BITS;     // 33 x 16 partial products
    localparam int C_W    = PROD_W + 2;          // signed map coordinate, Q.16
    localparam int WGT_W  = FRAC_BITS + 2;       // weights in (-1, 2), signed

    // blend path
    localparam int MP_W = WGT_W + WORD_W;        // weight * map word
    localparam int BL_W = MP_W + 1;              // row blend before rounding
    localparam int A_W  = BL_W - FRAC_BITS;      // row blend after rounding
    localparam int Q_W  = WGT_W + A_W;           // weight * row blend
    localparam int R_W  = Q_W + 1 - FRAC_BITS;   // final blend after rounding

    localparam int     ONE_Q16   = 65536;
    localparam int     HALF_Q16  = 32768;
    localparam longint WORD_MAX  = 64'sd2147483647;
    localparam longint WORD_MIN  = -64'sd2147483648;

    // pipeline shape
    localparam int LD_ST   = 8;    // map write happens on leaving stage 8
    localparam int SMP_ST  = 13;   // valid shift before the output register
    localparam int OK_ST   = 7;    // in-range flag, stages 7..13
    localparam int WGT_ST  = 5;    // weights, stages 7..11
    localparam int LATENCY = 14;

    typedef enum logic [1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_INV_PIXEL_SIZE
    } reg_idx_t;

    typedef struct packed {
        logic signed [WGT_W-1:0] wx;
        logic signed [WGT_W-1:0] fx;
        logic signed [WGT_W-1:0] wy;
        logic signed [WGT_W-1:0] fy;
    } wgt_t;

endpackage

>>> src/bms_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_axis - position to map cell for one axis
// Six register stages: offset, magnitude, split multiply, sum, recenter,
// then cell index, fraction, weight and the range check.
// ----------------------------------------------------------------------------
module bms_axis
    import bms_pkg::*;
#(
    parameter int DIM = 256
)
(
    input  logic                         clk,
    input  logic signed [WORD_W-1:0]     pos,
    input  logic signed [WORD_W-1:0]     center,
    input  logic        [WORD_W-1:0]     scale,
    output logic                         coord_ok,
    output logic        [$clog2(DIM)-1:0] idx,
    output logic signed [WGT_W-1:0]      frac,
    output logic signed [WGT_W-1:0]      wgt
);

    localparam int IW = $clog2(DIM);
    localparam logic signed [C_W-1:0] OFFSET =
        C_W'(longint'(DIM) * longint'(HALF_Q16) - longint'(HALF_Q16));
    localparam logic signed [C_W-1:0] C_HI = C_W'(longint'(DIM - 1) * longint'(ONE_Q16));
    localparam logic signed [C_W-1:0] C_LO = C_W'(-longint'(ONE_Q16));
    localparam logic signed [WGT_W-1:0] ONE_W = WGT_W'(ONE_Q16);

    logic signed [D_W-1:0]    d_reg;
    logic        [D_W-1:0]    mag_reg;
    logic                     neg2_reg;
    logic        [PROD_W-1:0] prod_hi_reg;
    logic        [PROD_W-1:0] prod_lo_reg;
    logic                     neg3_reg;
    logic        [PROD_W-1:0] r_reg;
    logic                     neg4_reg;
    logic signed [C_W-1:0]    c_reg;

    logic                     ok_next;
    logic        [IW-1:0]     idx_next;
    logic signed [WGT_W-1:0]  frac_next;

    logic                     ok_reg;
    logic        [IW-1:0]     idx_reg;
    logic signed [WGT_W-1:0]  frac_reg;
    logic signed [WGT_W-1:0]  wgt_reg;

    // truncation toward zero: a coordinate in (-1,0) lands in cell 0
    // and keeps its negative fraction
    always_comb
    begin
        ok_next = (c_reg > C_LO) && (c_reg < C_HI);
        if (c_reg[C_W-1])
        begin
            idx_next  = '0;
            frac_next = c_reg[WGT_W-1:0];
        end
        else
        begin
            idx_next  = c_reg[FRAC_BITS +: IW];
            frac_next = {2'b00, c_reg[FRAC_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= D_W'(pos) - D_W'(center);
        neg2_reg    <= d_reg[D_W-1];
        mag_reg     <= d_reg[D_W-1] ? $unsigned(-d_reg) : $unsigned(d_reg);
        neg3_reg    <= neg2_reg;
        prod_hi_reg <= PROD_W'(mag_reg) * PROD_W'(scale[WORD_W-1:FRAC_BITS]);
        prod_lo_reg <= PROD_W'(mag_reg) * PROD_W'(scale[FRAC_BITS-1:0]);
        neg4_reg    <= neg3_reg;
        r_reg       <= prod_hi_reg + (prod_lo_reg >> FRAC_BITS);
        c_reg       <= neg4_reg ? OFFSET - $signed({2'b00, r_reg})
                                : OFFSET + $signed({2'b00, r_reg});
        ok_reg      <= ok_next;
        idx_reg     <= idx_next;
        frac_reg    <= frac_next;
        wgt_reg     <= ONE_W - frac_next;
    end

    assign coord_ok = ok_reg;
    assign idx      = idx_reg;
    assign frac     = frac_reg;
    assign wgt      = wgt_reg;

endmodule

>>> src/bilinear_map_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_map_sampler - bilinear sampling of a stored source map
// Each sample word gives one result on done; load words give none.
// Throughput: one word (load or sample) per cycle; busy never rises.
// Four copies of the map, one per cell corner, give four reads each cycle.
// Reset clears valid bits, inits config; map words are undefined until loaded.
// ----------------------------------------------------------------------------
module bilinear_map_sampler
    import bms_pkg::*;
#(
    parameter int MAP_DIM_X = 256,
    parameter int MAP_DIM_Y = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      req_type,
    input  logic        [ADDR_W-1:0]  load_addr,
    input  logic signed [WORD_W-1:0]  load_value,
    input  logic signed [WORD_W-1:0]  pos_x,
    input  logic signed [WORD_W-1:0]  pos_y,
    input  logic                      last_sample,
    output logic                      done,
    output logic signed [WORD_W-1:0]  sample_value,
    output logic                      in_range,
    output logic                      last_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic        [PADDR_W-1:0] paddr,
    input  logic        [WORD_W-1:0]  pwdata,
    output logic        [WORD_W-1:0]  prdata,
    output logic                      pready
);

    localparam int XW = $clog2(MAP_DIM_X);
    localparam int YW = $clog2(MAP_DIM_Y);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAP_DIM_Y);

    logic                     accept;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    logic signed [WORD_W-1:0] center_x_reg;
    logic signed [WORD_W-1:0] center_y_reg;
    logic        [WORD_W-1:0] inv_pixel_size_reg;

    logic [SMP_ST-1:0]        smp_vld_reg;
    logic [SMP_ST-1:0]        last_reg;
    logic [LD_ST-1:0]         ld_vld_reg;
    logic [ADDR_W-1:0]        ld_addr_reg  [LD_ST];
    logic [WORD_W-1:0]        ld_value_reg [LD_ST];

    logic                     x_ok;
    logic [XW-1:0]            x_idx;
    logic signed [WGT_W-1:0]  x_frac;
    logic signed [WGT_W-1:0]  x_wgt;
    logic                     y_ok;
    logic [YW-1:0]            y_idx;
    logic signed [WGT_W-1:0]  y_frac;
    logic signed [WGT_W-1:0]  y_wgt;

    logic [OK_ST-1:0]         ok_reg;
    wgt_t                     wgt_reg [WGT_ST];
    logic [ADDR_W-1:0]        row_base_reg;
    logic [YW-1:0]            col_reg;
    logic [ADDR_W-1:0]        addr_reg [NUM_CORNERS];
    logic [WORD_W-1:0]        word_reg [NUM_CORNERS];
    logic signed [MP_W-1:0]   mp_reg   [NUM_CORNERS];
    logic signed [BL_W-1:0]   bl0_sum;
    logic signed [BL_W-1:0]   bl1_sum;
    logic signed [A_W-1:0]    a_reg;
    logic signed [A_W-1:0]    b_reg;
    logic signed [Q_W-1:0]    q0_reg;
    logic signed [Q_W-1:0]    q1_reg;
    logic signed [Q_W:0]      r_sum;
    logic signed [R_W-1:0]    r_reg;

    logic                     done_reg;
    logic signed [WORD_W-1:0] sample_value_reg;
    logic                     in_range_reg;
    logic                     last_out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            inv_pixel_size_reg <= WORD_W'(ONE_Q16);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CENTER_X:       center_x_reg       <= pwdata;
                REG_CENTER_Y:       center_y_reg       <= pwdata;
                REG_INV_PIXEL_SIZE: inv_pixel_size_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_CENTER_X:       prdata = center_x_reg;
            REG_CENTER_Y:       prdata = center_y_reg;
            REG_INV_PIXEL_SIZE: prdata = inv_pixel_size_reg;
            default:            prdata = '0;
        endcase
    end

    // ---------------- valid bits and load words ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg <= '0;
            ld_vld_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            smp_vld_reg <= {smp_vld_reg[SMP_ST-2:0], accept && req_type};
            ld_vld_reg  <= {ld_vld_reg[LD_ST-2:0], accept && !req_type};
            done_reg    <= smp_vld_reg[SMP_ST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg        <= {last_reg[SMP_ST-2:0], last_sample};
        ld_addr_reg[0]  <= load_addr;
        ld_value_reg[0] <= load_value;
        for (int k = 1; k < LD_ST; k++)
        begin
            ld_addr_reg[k]  <= ld_addr_reg[k-1];
            ld_value_reg[k] <= ld_value_reg[k-1];
        end
    end

    // ---------------- stages 1..6: map coordinates ----------------
    bms_axis #(.DIM(MAP_DIM_X)) u_axis_x
    (
        .clk      (clk),
        .pos      (pos_x),
        .center   (center_x_reg),
        .scale    (inv_pixel_size_reg),
        .coord_ok (x_ok),
        .idx      (x_idx),
        .frac     (x_frac),
        .wgt      (x_wgt)
    );

    bms_axis #(.DIM(MAP_DIM_Y)) u_axis_y
    (
        .clk      (clk),
        .pos      (pos_y),
        .center   (center_y_reg),
        .scale    (inv_pixel_size_reg),
        .coord_ok (y_ok),
        .idx      (y_idx),
        .frac     (y_frac),
        .wgt      (y_wgt)
    );

    // ---------------- stages 7..8: corner addresses ----------------
    always_ff @(posedge clk)
    begin
        ok_reg       <= {ok_reg[OK_ST-2:0], x_ok && y_ok};
        wgt_reg[0]   <= '{wx: x_wgt, fx: x_frac, wy: y_wgt, fy: y_frac};
        for (int k = 1; k < WGT_ST; k++)
        begin
            wgt_reg[k] <= wgt_reg[k-1];
        end
        row_base_reg <= ADDR_W'(32'(x_idx) * 32'(MAP_DIM_Y));
        col_reg      <= y_idx;
        // corner order: (i,j) (i,j+1) (i+1,j) (i+1,j+1), wrapping in the store
        addr_reg[0]  <= row_base_reg + ADDR_W'(col_reg);
        addr_reg[1]  <= row_base_reg + ADDR_W'(col_reg) + ADDR_W'(1);
        addr_reg[2]  <= row_base_reg + ADDR_W'(col_reg) + ROW_STEP;
        addr_reg[3]  <= row_base_reg + ADDR_W'(col_reg) + ROW_STEP + ADDR_W'(1);
    end

    // ---------------- stage 9: map copies ----------------
    // loads write at the same stage where samples read, so order is kept
    for (genvar b = 0; b < NUM_CORNERS; b++)
    begin : g_bank
        logic [WORD_W-1:0] bank_mem [MAP_DEPTH];

        always_ff @(posedge clk)
        begin
            if (ld_vld_reg[LD_ST-1])
            begin
                bank_mem[ld_addr_reg[LD_ST-1]] <= ld_value_reg[LD_ST-1];
            end
            word_reg[b] <= bank_mem[addr_reg[b]];
        end
    end

    // ---------------- stages 10..13: blend ----------------
    always_comb
    begin
        bl0_sum = BL_W'(mp_reg[0]) + BL_W'(mp_reg[1]) + BL_W'(HALF_Q16);
        bl1_sum = BL_W'(mp_reg[2]) + BL_W'(mp_reg[3]) + BL_W'(HALF_Q16);
        r_sum   = (Q_W+1)'(q0_reg) + (Q_W+1)'(q1_reg) + (Q_W+1)'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        mp_reg[0] <= $signed(wgt_reg[2].wy) * $signed(word_reg[0]);
        mp_reg[1] <= $signed(wgt_reg[2].fy) * $signed(word_reg[1]);
        mp_reg[2] <= $signed(wgt_reg[2].wy) * $signed(word_reg[2]);
        mp_reg[3] <= $signed(wgt_reg[2].fy) * $signed(word_reg[3]);
        a_reg     <= bl0_sum[BL_W-1:FRAC_BITS];
        b_reg     <= bl1_sum[BL_W-1:FRAC_BITS];
        q0_reg    <= $signed(wgt_reg[4].wx) * a_reg;
        q1_reg    <= $signed(wgt_reg[4].fx) * b_reg;
        r_reg     <= r_sum[Q_W:FRAC_BITS];
    end

    // ---------------- stage 14: saturate and present ----------------
    always_ff @(posedge clk)
    begin
        in_range_reg <= ok_reg[OK_ST-1];
        last_out_reg <= last_reg[SMP_ST-1];
        if (!ok_reg[OK_ST-1])
        begin
            sample_value_reg <= '0;
        end
        else if (r_reg > R_W'(WORD_MAX))
        begin
            sample_value_reg <= WORD_W'(WORD_MAX);
        end
        else if (r_reg < R_W'(WORD_MIN))
        begin
            sample_value_reg <= WORD_W'(WORD_MIN);
        end
        else
        begin
            sample_value_reg <= r_reg[WORD_W-1:0];
        end
    end

    assign done         = done_reg;
    assign sample_value = sample_value_reg;
    assign in_range     = in_range_reg;
    assign last_out     = last_out_reg;

endmodule

>>> src/bms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_checker - port-level checks for the bilinear map sampler
// Fixed latency, no result for loads, zero value outside the map.
// ----------------------------------------------------------------------------
module bms_checker
    import bms_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     req_type,
    input logic                     last_sample,
    input logic                     done,
    input logic signed [WORD_W-1:0] sample_value,
    input logic                     in_range,
    input logic                     last_out
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !req_type |-> ##LATENCY !done)
        else $error("load word produced a result");

    a_done_traced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && req_type, LATENCY)
                 && (last_out == $past(last_sample, LATENCY)))
        else $error("result word without matching sample");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_range |-> sample_value == '0)
        else $error("out-of-range result not zero");

endmodule

bind bilinear_map_sampler bms_checker u_bms_checker (.*);
